### hw/rtl/srrip_pkg.sv
// Package with the shared constants, types and codes of the SRRIP set replacement block.
`default_nettype none
package srrip_pkg;
    localparam int NUM_WAYS = 16;
    localparam int WAY_BITS = 4;
    localparam int TAG_BITS = 48;
    localparam int CNT_BITS = 5;
    localparam logic [CNT_BITS-1:0] CNT_MAX = 5'd31;
    localparam logic [1:0] EPOCH_MAX = 2'd3;
    localparam logic [2:0] RRPV_RESET = 3'd3;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_VICTIM = 3'd1;
    localparam logic [2:0] OP_FILL   = 3'd2;
    localparam logic [2:0] OP_HIT    = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;
    localparam logic [2:0] OP_COUNT  = 3'd5;

    localparam logic [0:0] CFG_MAX_RRPV = 1'd0;
    localparam logic [0:0] CFG_STREAM   = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SELECT
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
        logic select;
    } t_cmd;
endpackage
`default_nettype wire

### hw/rtl/srrip_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`default_nettype none
module srrip_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        i_is_victim,
    output logic             busy,
    output srrip_pkg::t_cmd  o_cmd
);
    srrip_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srrip_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srrip_pkg::S_IDLE: begin
                if (start) n_state = srrip_pkg::S_EXEC;
            end
            srrip_pkg::S_EXEC: begin
                n_state = i_is_victim ? srrip_pkg::S_SELECT : srrip_pkg::S_IDLE;
            end
            srrip_pkg::S_SELECT: n_state = srrip_pkg::S_IDLE;
            default: n_state = srrip_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy = 1'b1;
        case (r_state)
            srrip_pkg::S_IDLE: begin
                busy = 1'b0;
                o_cmd.capture = start;
            end
            srrip_pkg::S_EXEC: o_cmd.execute = 1'b1;
            srrip_pkg::S_SELECT: o_cmd.select = 1'b1;
            default: busy = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/srrip_dp.sv
// Datapath holding the way arrays, the configuration and the result registers.
`default_nettype none
module srrip_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  srrip_pkg::t_cmd                 i_cmd,
    output logic                            o_is_victim,
    input  wire logic                       i_cfg_we,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [7:0]                 i_cfg_data,
    input  wire logic [2:0]                 i_opcode,
    input  wire logic [3:0]                 i_way_index,
    input  wire logic [47:0]                i_tag,
    input  wire logic [2:0]                 i_new_state,
    input  wire logic [7:0]                 i_stream,
    input  wire logic [7:0]                 i_access_stream,
    input  wire logic                       i_fill_flag,
    input  wire logic                       i_spill,
    input  wire logic [15:0]                i_busy_mask,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [3:0]                      o_result_way,
    output logic [4:0]                      o_stream_count,
    output logic [4:0]                      o_counted_stream_blocks
);
    localparam int NW = srrip_pkg::NUM_WAYS;
    localparam int WB = srrip_pkg::WAY_BITS;
    localparam int TB = srrip_pkg::TAG_BITS;

    logic [2:0]    r_wstate [NW];
    logic [TB-1:0] r_wtag   [NW];
    logic [7:0]    r_wstream[NW];
    logic [2:0]    r_wrrpv  [NW];
    logic          r_wdirty [NW];
    logic [1:0]    r_wepoch [NW];
    logic [31:0]   r_wcount [NW];
    logic [4:0]    r_total;
    logic [2:0]    r_max;
    logic [7:0]    r_cstream;

    // Captured item.
    logic [2:0]    r_op;
    logic [WB-1:0] r_way;
    logic [TB-1:0] r_tag;
    logic [2:0]    r_nstate;
    logic [7:0]    r_strm, r_astrm;
    logic          r_fill, r_spill;
    logic [15:0]   r_busy;

    logic          r_valid, r_found;
    logic [3:0]    r_rway;
    logic [4:0]    r_scount;
    logic          r_recount;

    // Parallel per-way status.
    logic [NW-1:0] valid_v, hit_v, scnt_v, tot_v, atmax_v, pick_v;
    logic [2:0]    top;
    logic          any_inv, any_hit, any_pick;
    logic [WB-1:0] inv_way, hit_way, pick_way;
    logic [4:0]    scnt_sum, tot_sum;

    always_comb begin
        top = '0;
        any_inv = 1'b0; inv_way = '0;
        any_hit = 1'b0; hit_way = '0;
        any_pick = 1'b0; pick_way = '0;
        for (int w = 0; w < NW; w++) begin
            valid_v[w] = r_wstate[w] != 3'd0;
            hit_v[w]   = valid_v[w] && r_wtag[w] == r_tag;
            scnt_v[w]  = valid_v[w] && r_wstream[w] == r_strm;
            tot_v[w]   = valid_v[w] && r_wstream[w] == r_cstream;
            atmax_v[w] = r_wrrpv[w] >= r_max;
            pick_v[w]  = atmax_v[w] && !((w < 16) ? r_busy[w % 16] : 1'b0);
            if (r_wrrpv[w] > top) top = r_wrrpv[w];
        end
        for (int w = NW - 1; w >= 0; w--) begin
            if (!valid_v[w]) begin any_inv = 1'b1; inv_way = WB'(w); end
            if (hit_v[w]) begin any_hit = 1'b1; hit_way = WB'(w); end
            if (pick_v[w]) begin any_pick = 1'b1; pick_way = WB'(w); end
        end
        scnt_sum = ($countones(scnt_v) > int'(srrip_pkg::CNT_MAX))
            ? srrip_pkg::CNT_MAX : 5'($countones(scnt_v));
        tot_sum = ($countones(tot_v) > int'(srrip_pkg::CNT_MAX))
            ? srrip_pkg::CNT_MAX : 5'($countones(tot_v));
    end

    logic          tgt_valid, was_counted, after;
    logic [2:0]    ins_rrpv;
    logic [4:0]    tot_adj;
    assign o_is_victim = r_op == srrip_pkg::OP_VICTIM && !any_inv;
    assign tgt_valid = r_wstate[r_way] != 3'd0;
    assign was_counted = tgt_valid && r_wstream[r_way] == r_cstream;
    assign ins_rrpv = r_fill ? ((r_max != 3'd0) ? r_max - 3'd1 : 3'd0) : r_max;

    logic op_fill, op_hit, op_set;
    assign op_fill = r_op == srrip_pkg::OP_FILL && r_nstate != 3'd0;
    assign op_hit  = r_op == srrip_pkg::OP_HIT && tgt_valid;
    assign op_set  = r_op == srrip_pkg::OP_SET && tgt_valid && r_wtag[r_way] == r_tag;
    always_comb begin
        after = was_counted;
        if (op_fill || op_hit || (op_set && r_nstate != 3'd0)) after = r_strm == r_cstream;
        else if (op_set) after = 1'b0;
        tot_adj = r_total;
        if (was_counted && !after && r_total != 5'd0) tot_adj = r_total - 5'd1;
        if (!was_counted && after && r_total != srrip_pkg::CNT_MAX) tot_adj = r_total + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NW; w++) begin
                r_wstate[w] <= '0; r_wtag[w] <= '0; r_wstream[w] <= '0;
                r_wrrpv[w] <= '0; r_wdirty[w] <= 1'b0; r_wepoch[w] <= '0;
                r_wcount[w] <= '0;
            end
            r_total <= '0;
            r_max <= srrip_pkg::RRPV_RESET;
            r_cstream <= '0;
            r_valid <= 1'b0;
            r_recount <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_recount <= 1'b0;
            // The total is recounted in the cycle after a stream write.
            if (r_recount) r_total <= tot_sum;
            if (i_cfg_we) begin
                if (i_cfg_index == srrip_pkg::CFG_MAX_RRPV) begin
                    r_max <= i_cfg_data[2:0];
                    for (int w = 0; w < NW; w++)
                        if (r_wrrpv[w] > i_cfg_data[2:0]) r_wrrpv[w] <= i_cfg_data[2:0];
                end else begin
                    r_cstream <= i_cfg_data;
                    r_recount <= 1'b1;
                end
            end
            if (i_cmd.capture) begin
                r_op <= i_opcode; r_way <= i_way_index; r_tag <= i_tag;
                r_nstate <= i_new_state; r_strm <= i_stream; r_astrm <= i_access_stream;
                r_fill <= i_fill_flag; r_spill <= i_spill; r_busy <= i_busy_mask;
            end
            if (i_cmd.execute) begin
                r_found <= 1'b0; r_rway <= '0; r_scount <= '0;
                r_valid <= !o_is_victim;
                case (r_op)
                    srrip_pkg::OP_LOOKUP: begin r_found <= any_hit; r_rway <= hit_way; end
                    srrip_pkg::OP_VICTIM: begin
                        if (any_inv) begin r_found <= 1'b1; r_rway <= inv_way; end
                        else if (atmax_v == '0)
                            // Age all ways so the highest one reaches the eviction level.
                            for (int w = 0; w < NW; w++)
                                r_wrrpv[w] <= r_wrrpv[w] + (r_max - top);
                    end
                    srrip_pkg::OP_FILL: if (op_fill) begin
                        r_wstate[r_way] <= r_nstate; r_wtag[r_way] <= r_tag;
                        r_wstream[r_way] <= r_strm; r_wdirty[r_way] <= r_spill;
                        r_wepoch[r_way] <= '0; r_wcount[r_way] <= '0;
                        r_wrrpv[r_way] <= ins_rrpv; r_total <= tot_adj;
                    end
                    srrip_pkg::OP_HIT: if (op_hit) begin
                        if (r_fill) begin
                            r_wrrpv[r_way] <= '0;
                            if (r_wstream[r_way] == r_astrm)
                                r_wepoch[r_way] <= (r_wepoch[r_way] == srrip_pkg::EPOCH_MAX)
                                    ? srrip_pkg::EPOCH_MAX : r_wepoch[r_way] + 2'd1;
                            else r_wepoch[r_way] <= '0;
                        end
                        r_wstream[r_way] <= r_strm; r_wdirty[r_way] <= r_spill;
                        if (r_wcount[r_way] != '1) r_wcount[r_way] <= r_wcount[r_way] + 32'd1;
                        r_total <= tot_adj;
                    end
                    srrip_pkg::OP_SET: if (op_set) begin
                        if (r_nstate != 3'd0) begin
                            r_wstate[r_way] <= r_nstate; r_wstream[r_way] <= r_strm;
                        end else begin
                            r_wstate[r_way] <= '0; r_wstream[r_way] <= '0;
                            r_wrrpv[r_way] <= '0; r_wepoch[r_way] <= '0;
                            r_wcount[r_way] <= '0;
                        end
                        r_total <= tot_adj;
                    end
                    srrip_pkg::OP_COUNT: r_scount <= scnt_sum;
                    default: ;
                endcase
            end
            if (i_cmd.select) begin
                r_valid <= 1'b1;
                r_found <= any_pick;
                r_rway <= any_pick ? pick_way : '0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_found = r_found;
    assign o_result_way = r_rway;
    assign o_stream_count = r_scount;
    assign o_counted_stream_blocks = r_total;
endmodule
`default_nettype wire

### hw/rtl/srrip_set_replacement.sv
// Top level of one cache set under SRRIP replacement.
// An item is taken when start is high and busy is low; its result appears on the o_ ports
// for one cycle with o_done high. Victim select without an invalid way goes through capture,
// aging and a pick over the aged RRPVs; every other opcode goes through capture, then the
// parallel tag or stream compare and update. The receiver cannot stall results. After a write
// of counted_stream the running total is recounted in the following cycle.
`default_nettype none
module srrip_set_replacement (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [3:0]  i_way_index,
    input  wire logic [47:0] i_tag,
    input  wire logic [2:0]  i_new_state,
    input  wire logic [7:0]  i_stream,
    input  wire logic [7:0]  i_access_stream,
    input  wire logic        i_fill_flag,
    input  wire logic        i_spill,
    input  wire logic [15:0] i_busy_mask,
    output logic             o_done,
    output logic             o_found,
    output logic [3:0]       o_result_way,
    output logic [4:0]       o_stream_count,
    output logic [4:0]       o_counted_stream_blocks
);
    srrip_pkg::t_cmd cmd;
    logic is_victim;

    srrip_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_is_victim(is_victim), .busy, .o_cmd(cmd)
    );

    srrip_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_is_victim(is_victim),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_opcode, .i_way_index, .i_tag, .i_new_state, .i_stream, .i_access_stream,
        .i_fill_flag, .i_spill, .i_busy_mask,
        .o_valid(o_done), .o_found, .o_result_way, .o_stream_count, .o_counted_stream_blocks
    );
endmodule
`default_nettype wire
